// ===== design/brwt_pkg.sv =====
// ----------------------------------------------------------------------------
// brwt_pkg
// Shared types and codes for the beacon route and wave timer unit.
// ----------------------------------------------------------------------------
package brwt_pkg;

	// Request type codes as they arrive on req_type
	localparam logic [1:0] REQ_BEACON    = 2'd0;
	localparam logic [1:0] REQ_TICK      = 2'd1;
	localparam logic [1:0] REQ_SEND_DONE = 2'd2;

	// LED command codes carried in a beacon
	localparam logic [7:0] CODE_YELLOW_ON  = 8'd1;
	localparam logic [7:0] CODE_YELLOW_OFF = 8'd2;
	localparam logic [7:0] CODE_BLINK      = 8'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_LOCAL_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_REFRESH_TICKS = 2'd1;
	localparam logic [1:0] CFG_LEVEL_LIMIT   = 2'd2;

	// Reset values
	localparam logic [7:0] POT_RESET     = 8'd72;
	localparam logic [7:0] REFRESH_RESET = 8'd16;
	localparam logic [4:0] LIMIT_RESET   = 5'd20;
	localparam logic [4:0] LIMIT_FLOOR   = 5'd2;

	// Decoded item kind
	typedef enum logic [1:0] {
		OP_BEACON,
		OP_TICK,
		OP_SEND_DONE,
		OP_NONE
	} op_kind_t;

	// Decoded LED command
	typedef enum logic [1:0] {
		LED_NONE,
		LED_YELLOW_ON,
		LED_YELLOW_OFF,
		LED_BLINK
	} led_cmd_t;

	// Blink wave phase
	typedef enum logic [1:0] {
		PHASE_IDLE,
		PHASE_RUN
	} wave_phase_t;

	// Classified item passed from the front end to the back end
	typedef struct packed {
		op_kind_t   kind;
		led_cmd_t   cmd;
		logic [15:0] sender;
		logic [7:0]  hops;
		logic [7:0]  duration;
		logic [7:0]  delay;
		logic        reverse;
		logic [7:0]  pot;
		logic        accepted;
	} op_t;

endpackage

// ===== design/brwt_front.sv =====
// ----------------------------------------------------------------------------
// brwt_front
// Classifies an incoming item: decodes its kind and LED command, increments
// the hop count and reduces the wave direction to one bit.
// ----------------------------------------------------------------------------
module brwt_front (
	input  logic [1:0]   req_type,
	input  logic [15:0]  sender,
	input  logic [7:0]   beacon_hops,
	input  logic [7:0]   command,
	input  logic [7:0]   led_duration,
	input  logic [7:0]   led_delay,
	input  logic [7:0]   wave_reverse,
	input  logic [7:0]   pot_request,
	input  logic         send_accepted,
	output brwt_pkg::op_t op
);
	import brwt_pkg::*;

	// Decode kind and command, build the queue entry
	always_comb begin
		op = '0;
		case (req_type)
			REQ_BEACON:    op.kind = OP_BEACON;
			REQ_TICK:      op.kind = OP_TICK;
			REQ_SEND_DONE: op.kind = OP_SEND_DONE;
			default:       op.kind = OP_NONE;
		endcase
		case (command)
			CODE_YELLOW_ON:  op.cmd = LED_YELLOW_ON;
			CODE_YELLOW_OFF: op.cmd = LED_YELLOW_OFF;
			CODE_BLINK:      op.cmd = LED_BLINK;
			default:         op.cmd = LED_NONE;
		endcase
		op.sender   = sender;
		op.hops     = beacon_hops + 8'd1;
		op.duration = led_duration;
		op.delay    = led_delay;
		op.reverse  = (wave_reverse != 8'd0);
		op.pot      = pot_request;
		op.accepted = send_accepted;
	end

endmodule

// ===== design/brwt_queue.sv =====
// ----------------------------------------------------------------------------
// brwt_queue
// Small FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module brwt_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  brwt_pkg::op_t push_op,
	output logic          pop_valid,
	input  logic          pop_ready,
	output brwt_pkg::op_t pop_op
);
	import brwt_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	op_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_op     = mem_q[rd_ptr_q];

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/brwt_back.sv =====
// ----------------------------------------------------------------------------
// brwt_back
// Executes classified items against the route, LED, wave and pot state and
// holds the result beat in an output register.
// ----------------------------------------------------------------------------
module brwt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic          op_valid,
	output logic          op_ready,
	input  brwt_pkg::op_t op,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          forward_valid,
	output logic [15:0]   forward_source,
	output logic [7:0]    forward_hops,
	output logic [15:0]   parent_address,
	output logic [4:0]    node_level,
	output logic          yellow_on,
	output logic          green_on,
	output logic          red_on,
	output logic [7:0]    pot_value,
	output logic          pot_load
);
	import brwt_pkg::*;

	// Configuration
	logic [15:0] local_address_q;
	logic [7:0]  refresh_ticks_q;
	logic [4:0]  level_limit_q;

	// Block state
	logic [7:0]  route_timer_q, route_timer_d;
	logic [15:0] parent_q, parent_d;
	logic [4:0]  level_q, level_d;
	wave_phase_t phase_q, phase_d;
	logic [12:0] delay_q, delay_d;
	logic [7:0]  duration_q, duration_d;
	logic [3:0]  heartbeat_q, heartbeat_d;
	logic        pending_q, pending_d;
	logic        yellow_q, yellow_d;
	logic        green_q, green_d;
	logic [7:0]  pot_q, pot_d;

	// Output register
	logic        out_valid_q;
	logic        fwd_valid_q, fwd_valid_d;
	logic [15:0] fwd_source_q, fwd_source_d;
	logic [7:0]  fwd_hops_q, fwd_hops_d;
	logic        pot_load_q, pot_load_d;

	logic        fire;
	logic        adopt;
	logic        start_wave;
	logic [4:0]  limit;
	logic [4:0]  top_level;
	logic [4:0]  new_level;
	logic [4:0]  wave_factor;
	logic [12:0] wave_delay;

	assign cfg_ready = 1'b1;
	assign op_ready  = !out_valid_q || out_ready;
	assign fire      = op_valid && op_ready;

	// Adopt a beacon only when the route has expired
	assign adopt      = fire && (op.kind == OP_BEACON) && (route_timer_q == 8'd0);
	assign start_wave = adopt && (op.cmd == LED_BLINK) && (phase_q == PHASE_IDLE);

	// Level saturation and wave delay
	assign limit       = (level_limit_q < LIMIT_FLOOR) ? LIMIT_FLOOR : level_limit_q;
	assign top_level   = limit - 5'd1;
	assign new_level   = (op.hops >= {3'd0, top_level}) ? top_level : op.hops[4:0];
	assign wave_factor = op.reverse ? (limit - new_level) : new_level;
	assign wave_delay  = 13'(op.delay) * 13'(wave_factor);

	// Next wave phase
	always_comb begin
		phase_d = phase_q;
		if (start_wave) begin
			phase_d = PHASE_RUN;
		end else if (fire && op.kind == OP_TICK && phase_q == PHASE_RUN
			&& delay_q == 13'd0 && duration_q == 8'd1) begin
			phase_d = PHASE_IDLE;
		end
	end

	// Next datapath state and result fields
	always_comb begin
		route_timer_d = route_timer_q;
		parent_d      = parent_q;
		level_d       = level_q;
		delay_d       = delay_q;
		duration_d    = duration_q;
		heartbeat_d   = heartbeat_q;
		pending_d     = pending_q;
		yellow_d      = yellow_q;
		green_d       = green_q;
		pot_d         = pot_q;
		fwd_valid_d   = 1'b0;
		fwd_source_d  = '0;
		fwd_hops_d    = '0;
		pot_load_d    = 1'b0;
		if (adopt) begin
			case (op.cmd)
				LED_YELLOW_ON:  yellow_d = 1'b1;
				LED_YELLOW_OFF: yellow_d = 1'b0;
				LED_BLINK:      if (phase_q == PHASE_IDLE) yellow_d = 1'b1;
				default:        yellow_d = yellow_q;
			endcase
			parent_d      = op.sender;
			level_d       = new_level;
			route_timer_d = refresh_ticks_q;
			if (start_wave) begin
				delay_d    = wave_delay;
				duration_d = op.duration;
			end
			if (op.pot != pot_q) begin
				pot_d      = op.pot;
				pot_load_d = 1'b1;
			end
			if (!pending_q) begin
				pending_d = op.accepted;
				if (op.accepted) begin
					fwd_valid_d  = 1'b1;
					fwd_source_d = local_address_q;
					fwd_hops_d   = op.hops;
				end
			end
		end else if (fire && op.kind == OP_TICK) begin
			heartbeat_d = heartbeat_q + 4'd1;
			if (phase_q == PHASE_RUN) begin
				if (delay_q != 13'd0) begin
					delay_d = delay_q - 13'd1;
					if (delay_q == 13'd1) green_d = 1'b1;
				end else if (duration_q != 8'd0) begin
					duration_d = duration_q - 8'd1;
					if (duration_q == 8'd1) green_d = 1'b0;
				end
			end
			if (route_timer_q != 8'd0) begin
				route_timer_d = route_timer_q - 8'd1;
			end
		end else if (fire && op.kind == OP_SEND_DONE) begin
			pending_d = 1'b0;
		end
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= '0;
			refresh_ticks_q <= REFRESH_RESET;
			level_limit_q   <= LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LOCAL_ADDRESS: local_address_q <= cfg_data;
				CFG_REFRESH_TICKS: refresh_ticks_q <= cfg_data[7:0];
				CFG_LEVEL_LIMIT:   level_limit_q   <= cfg_data[4:0];
				default:           local_address_q <= local_address_q;
			endcase
		end
	end

	// Update state on each executed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_timer_q <= '0;
			parent_q      <= '0;
			level_q       <= '0;
			phase_q       <= PHASE_IDLE;
			delay_q       <= '0;
			duration_q    <= '0;
			heartbeat_q   <= '0;
			pending_q     <= 1'b0;
			yellow_q      <= 1'b0;
			green_q       <= 1'b0;
			pot_q         <= POT_RESET;
		end else if (fire) begin
			route_timer_q <= route_timer_d;
			parent_q      <= parent_d;
			level_q       <= level_d;
			phase_q       <= phase_d;
			delay_q       <= delay_d;
			duration_q    <= duration_d;
			heartbeat_q   <= heartbeat_d;
			pending_q     <= pending_d;
			yellow_q      <= yellow_d;
			green_q       <= green_d;
			pot_q         <= pot_d;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			fwd_valid_q  <= fwd_valid_d;
			fwd_source_q <= fwd_source_d;
			fwd_hops_q   <= fwd_hops_d;
			pot_load_q   <= pot_load_d;
		end
	end

	// State fields hold still while a beat waits, so read them directly
	assign out_valid      = out_valid_q;
	assign forward_valid  = fwd_valid_q;
	assign forward_source = fwd_source_q;
	assign forward_hops   = fwd_hops_q;
	assign pot_load       = pot_load_q;
	assign parent_address = parent_q;
	assign node_level     = level_q;
	assign yellow_on      = yellow_q;
	assign green_on       = green_q;
	assign red_on         = ~heartbeat_q[3];
	assign pot_value      = pot_q;

endmodule

// ===== design/beacon_route_and_wave_timer_unit.sv =====
// ----------------------------------------------------------------------------
// beacon_route_and_wave_timer_unit
// Route beacon handler with heartbeat and green blink-wave timer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item per beat: a beacon, a
//   timer tick or a send-done event. Output channel (out_valid/out_ready)
//   returns exactly one result beat per item, in order.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
//   always ready; write it only while no item is in flight.
//   Path: an accepted item is written into the queue register, and the
//   execute stage then loads its result into the output register, which
//   presents the result beat.
//   Throughput: one item per cycle while the receiver takes each beat; the
//   execute stage does all state updates plus one 8x5 multiply for the wave
//   delay. A stalled receiver holds the result beat; the queue keeps absorbing
//   items until it fills (QUEUE_DEPTH entries), then in_ready drops.
//   Reset clears route, level, yellow and green LEDs, counters and queue;
//   pot returns to 72, refresh to 16 ticks and level limit to 20.
// ----------------------------------------------------------------------------
module beacon_route_and_wave_timer_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [15:0] sender,
	input  logic [7:0]  beacon_hops,
	input  logic [7:0]  command,
	input  logic [7:0]  led_duration,
	input  logic [7:0]  led_delay,
	input  logic [7:0]  wave_reverse,
	input  logic [7:0]  pot_request,
	input  logic        send_accepted,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        forward_valid,
	output logic [15:0] forward_source,
	output logic [7:0]  forward_hops,
	output logic [15:0] parent_address,
	output logic [4:0]  node_level,
	output logic        yellow_on,
	output logic        green_on,
	output logic        red_on,
	output logic [7:0]  pot_value,
	output logic        pot_load
);
	import brwt_pkg::*;

	op_t  front_op;
	op_t  back_op;
	logic back_valid;
	logic back_ready;

	// Classify incoming items
	brwt_front u_front (
		.req_type      (req_type),
		.sender        (sender),
		.beacon_hops   (beacon_hops),
		.command       (command),
		.led_duration  (led_duration),
		.led_delay     (led_delay),
		.wave_reverse  (wave_reverse),
		.pot_request   (pot_request),
		.send_accepted (send_accepted),
		.op            (front_op)
	);

	// Decouple front and back
	brwt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_op    (front_op),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_op     (back_op)
	);

	// Execute items and drive results
	brwt_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.op_valid       (back_valid),
		.op_ready       (back_ready),
		.op             (back_op),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.forward_valid  (forward_valid),
		.forward_source (forward_source),
		.forward_hops   (forward_hops),
		.parent_address (parent_address),
		.node_level     (node_level),
		.yellow_on      (yellow_on),
		.green_on       (green_on),
		.red_on         (red_on),
		.pot_value      (pot_value),
		.pot_load       (pot_load)
	);

endmodule

// ===== test/beacon_route_and_wave_timer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// beacon_route_and_wave_timer_unit_tb
// Drives beacons, ticks and send-done items into the unit and checks each
// result beat against a cycle-free model of the route, LED and pot state.
// Covers directed corner cases, random traffic under several idling mixes,
// a long receiver hold-off and a wave that never ends.
// ----------------------------------------------------------------------------
module beacon_route_and_wave_timer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import brwt_pkg::*;

	// Request code that the unit treats as no operation
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] sender;
		logic [7:0]  beacon_hops;
		logic [7:0]  command;
		logic [7:0]  led_duration;
		logic [7:0]  led_delay;
		logic [7:0]  wave_reverse;
		logic [7:0]  pot_request;
		logic        send_accepted;
	} route_item_t;

	typedef struct packed {
		logic        forward_valid;
		logic [15:0] forward_source;
		logic [7:0]  forward_hops;
		logic [15:0] parent_address;
		logic [4:0]  node_level;
		logic        yellow_on;
		logic        green_on;
		logic        red_on;
		logic [7:0]  pot_value;
		logic        pot_load;
	} node_status_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [15:0] sender;
	logic [7:0]  beacon_hops;
	logic [7:0]  command;
	logic [7:0]  led_duration;
	logic [7:0]  led_delay;
	logic [7:0]  wave_reverse;
	logic [7:0]  pot_request;
	logic        send_accepted;
	logic        out_valid;
	logic        out_ready;
	logic        forward_valid;
	logic [15:0] forward_source;
	logic [7:0]  forward_hops;
	logic [15:0] parent_address;
	logic [4:0]  node_level;
	logic        yellow_on;
	logic        green_on;
	logic        red_on;
	logic [7:0]  pot_value;
	logic        pot_load;

	// Model copy of the registers and state
	logic [15:0] addr_reg;
	logic [7:0]  refresh_reg;
	logic [4:0]  limit_reg;
	logic [7:0]  route_left;
	logic [15:0] parent_m;
	logic [4:0]  level_m;
	wave_phase_t wave_m;
	logic [12:0] delay_left;
	logic [7:0]  lit_left;
	logic [3:0]  heartbeat_m;
	logic        send_busy;
	logic        yellow_m;
	logic        green_m;
	logic [7:0]  pot_m;

	node_status_t status_q[$];
	int failures = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;

	beacon_route_and_wave_timer_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.sender        (sender),
		.beacon_hops   (beacon_hops),
		.command       (command),
		.led_duration  (led_duration),
		.led_delay     (led_delay),
		.wave_reverse  (wave_reverse),
		.pot_request   (pot_request),
		.send_accepted (send_accepted),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.forward_valid (forward_valid),
		.forward_source(forward_source),
		.forward_hops  (forward_hops),
		.parent_address(parent_address),
		.node_level    (node_level),
		.yellow_on     (yellow_on),
		.green_on      (green_on),
		.red_on        (red_on),
		.pot_value     (pot_value),
		.pot_load      (pot_load)
	);

	always #2 clk = ~clk;

	// Advance the model by one item and return the status it reports
	function automatic node_status_t route_node_step(input route_item_t it);
		node_status_t r;
		logic [7:0]  next_hops;
		logic [4:0]  lim;
		logic [4:0]  factor;
		logic        arm;
		r = '0;
		arm = 1'b0;
		next_hops = it.beacon_hops + 8'd1;
		lim = (limit_reg < LIMIT_FLOOR) ? LIMIT_FLOOR : limit_reg;
		case (it.kind)
			REQ_BEACON: begin
				// drop the beacon while the current route is still fresh
				if (route_left == 8'd0) begin
					if (it.command == CODE_YELLOW_ON) begin
						yellow_m = 1'b1;
					end else if (it.command == CODE_YELLOW_OFF) begin
						yellow_m = 1'b0;
					end else if (it.command == CODE_BLINK && wave_m == PHASE_IDLE) begin
						yellow_m = 1'b1;
						arm = 1'b1;
					end
					parent_m = it.sender;
					level_m = (next_hops >= {3'd0, lim - 5'd1}) ? lim - 5'd1 : next_hops[4:0];
					route_left = refresh_reg;
					if (arm) begin
						factor = (it.wave_reverse == 8'd0) ? level_m : lim - level_m;
						wave_m = PHASE_RUN;
						delay_left = {5'd0, it.led_delay} * {8'd0, factor};
						lit_left = it.led_duration;
					end
					if (it.pot_request != pot_m) begin
						pot_m = it.pot_request;
						r.pot_load = 1'b1;
					end
					if (!send_busy) begin
						send_busy = it.send_accepted;
						if (it.send_accepted) begin
							r.forward_valid = 1'b1;
							r.forward_source = addr_reg;
							r.forward_hops = next_hops;
						end
					end
				end
			end
			REQ_TICK: begin
				heartbeat_m = heartbeat_m + 4'd1;
				if (wave_m == PHASE_RUN) begin
					if (delay_left != 13'd0) begin
						delay_left = delay_left - 13'd1;
						if (delay_left == 13'd0)
							green_m = 1'b1;
					end else if (lit_left != 8'd0) begin
						lit_left = lit_left - 8'd1;
						if (lit_left == 8'd0) begin
							green_m = 1'b0;
							wave_m = PHASE_IDLE;
						end
					end
				end
				if (route_left != 8'd0)
					route_left = route_left - 8'd1;
			end
			REQ_SEND_DONE: send_busy = 1'b0;
			default: ;
		endcase
		r.parent_address = parent_m;
		r.node_level = level_m;
		r.yellow_on = yellow_m;
		r.green_on = green_m;
		r.red_on = ~heartbeat_m[3];
		r.pot_value = pot_m;
		return r;
	endfunction

	function automatic route_item_t make_item(input logic [1:0] kind, input logic [15:0] src,
			input logic [7:0] hops, input logic [7:0] cmd, input logic [7:0] dur,
			input logic [7:0] dly, input logic [7:0] rev, input logic [7:0] pot,
			input logic acc);
		route_item_t it;
		it = '{kind, src, hops, cmd, dur, dly, rev, pot, acc};
		return it;
	endfunction

	// Build a random item, biased toward adoptable beacons and short waves
	function automatic route_item_t random_item();
		route_item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		it.kind = (pick < 40) ? REQ_BEACON : (pick < 85) ? REQ_TICK :
			(pick < 97) ? REQ_SEND_DONE : REQ_UNKNOWN;
		it.sender = 16'($urandom_range(0, 16'hFFFF));
		pick = $urandom_range(0, 9);
		it.beacon_hops = (pick < 3) ? 8'($urandom_range(0, 2)) :
			(pick == 3) ? 8'($urandom_range(253, 255)) : 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 3);
		it.command = (pick == 0) ? CODE_YELLOW_ON : (pick == 1) ? CODE_YELLOW_OFF :
			(pick == 2) ? CODE_BLINK : 8'($urandom_range(0, 255));
		it.led_duration = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255)) :
			8'($urandom_range(1, 6));
		it.wave_reverse = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 255)) : 8'd0;
		it.led_delay = 8'($urandom_range(0, 4));
		// keep long delays to level one so a wave ends within a few hundred ticks
		if ($urandom_range(0, 24) == 0) begin
			it.led_delay = 8'($urandom_range(0, 255));
			it.beacon_hops = 8'd0;
			it.wave_reverse = 8'd0;
		end
		it.pot_request = ($urandom_range(0, 1) != 0) ? pot_m : 8'($urandom_range(0, 255));
		it.send_accepted = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// Offer one item, optionally after an idle gap, and record its status
	task automatic send_item(input route_item_t it);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		req_type <= it.kind;
		sender <= it.sender;
		beacon_hops <= it.beacon_hops;
		command <= it.command;
		led_duration <= it.led_duration;
		led_delay <= it.led_delay;
		wave_reverse <= it.wave_reverse;
		pot_request <= it.pot_request;
		send_accepted <= it.send_accepted;
		do @(posedge clk); while (!in_ready);
		status_q.push_back(route_node_step(it));
	endtask

	task automatic send_ticks(input int count);
		repeat (count)
			send_item(make_item(REQ_TICK, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 1'b0));
	endtask

	// Hold the input idle until every expected beat has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (status_q.size() != 0);
	endtask

	// Write all three registers back to back; call only while drained
	task automatic program_registers(input logic [15:0] addr, input logic [7:0] refresh,
			input logic [4:0] limit);
		logic [1:0]  idx [3];
		logic [15:0] val [3];
		idx = '{CFG_LOCAL_ADDRESS, CFG_REFRESH_TICKS, CFG_LEVEL_LIMIT};
		val = '{addr, {8'd0, refresh}, {11'd0, limit}};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		addr_reg = addr;
		refresh_reg = refresh;
		limit_reg = limit;
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endtask

	task automatic check_result();
		node_status_t want;
		if (status_q.size() == 0) begin
			$error("result beat arrived with no status expected");
			failures++;
		end else begin
			want = status_q.pop_front();
			check_field("forward_valid", 16'(want.forward_valid), 16'(forward_valid));
			check_field("forward_source", want.forward_source, forward_source);
			check_field("forward_hops", 16'(want.forward_hops), 16'(forward_hops));
			check_field("parent_address", want.parent_address, parent_address);
			check_field("node_level", 16'(want.node_level), 16'(node_level));
			check_field("yellow_on", 16'(want.yellow_on), 16'(yellow_on));
			check_field("green_on", 16'(want.green_on), 16'(green_on));
			check_field("red_on", 16'(want.red_on), 16'(red_on));
			check_field("pot_value", 16'(want.pot_value), 16'(pot_value));
			check_field("pot_load", 16'(want.pot_load), 16'(pot_load));
		end
	endtask

	// Receiver: check each beat, then pick ready for the next edge
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				check_result();
			if (hold_off > 0) begin
				out_ready <= 1'b0;
				hold_off--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Corner cases: ignored beacons, saturation, refused and pending sends, waves
	task automatic test_directed_cases();
		program_registers(16'hFFFF, 8'd1, 5'd5);
		send_item(make_item(REQ_UNKNOWN, 16'h1234, 8'h56, CODE_BLINK, 8'd1, 8'd1, 8'd0,
			8'd9, 1'b1));
		send_item(make_item(REQ_BEACON, 16'hFFFF, 8'd0, CODE_YELLOW_ON, 8'd1, 8'd0, 8'd0,
			POT_RESET, 1'b1));
		// route still fresh: nothing changes
		send_item(make_item(REQ_BEACON, 16'h0001, 8'd7, CODE_YELLOW_OFF, 8'd1, 8'd0, 8'd0,
			8'd1, 1'b1));
		send_ticks(1);
		// hop count wraps to zero; send still pending so no forward
		send_item(make_item(REQ_BEACON, 16'h0000, 8'hFF, CODE_YELLOW_OFF, 8'd1, 8'd0, 8'd0,
			8'hFF, 1'b1));
		send_item(make_item(REQ_SEND_DONE, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 1'b0));
		send_ticks(1);
		// refused send, level saturates at limit minus one
		send_item(make_item(REQ_BEACON, 16'hA5A5, 8'hFE, 8'hFF, 8'd1, 8'd0, 8'd0,
			8'h00, 1'b0));
		send_ticks(1);
		send_item(make_item(REQ_BEACON, 16'h5A5A, 8'd2, CODE_BLINK, 8'd2, 8'd2, 8'd0,
			8'h00, 1'b1));
		send_ticks(1);
		send_item(make_item(REQ_BEACON, 16'h0F0F, 8'd1, CODE_YELLOW_OFF, 8'd1, 8'd0, 8'd0,
			8'h00, 1'b1));
		send_ticks(1);
		// blink while the wave runs is ignored
		send_item(make_item(REQ_BEACON, 16'hF0F0, 8'd0, CODE_BLINK, 8'd9, 8'd9, 8'd0,
			8'h00, 1'b1));
		send_ticks(6);
		// zero delay, reversed: green never lights
		send_item(make_item(REQ_BEACON, 16'h3C3C, 8'd0, CODE_BLINK, 8'd3, 8'd0, 8'h80,
			8'h11, 1'b1));
		send_ticks(3);
		send_item(make_item(REQ_BEACON, 16'hC3C3, 8'd3, CODE_BLINK, 8'd1, 8'd1, 8'h01,
			8'h22, 1'b0));
		send_ticks(2);
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct,
			input int stall_pct, input logic [15:0] addr, input logic [7:0] refresh,
			input logic [4:0] limit);
		wait_drained();
		program_registers(addr, refresh, limit);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_item(random_item());
	endtask

	// Stall the receiver long enough to fill the unit, then drain and let the
	// longest route expire
	task automatic test_backpressure();
		wait_drained();
		program_registers(16'h1234, 8'd255, 5'd31);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 300;
		repeat (40)
			send_item(random_item());
		wait_drained();
		send_ticks(256);
		send_item(make_item(REQ_BEACON, 16'h7E57, 8'd40, CODE_YELLOW_ON, 8'd1, 8'd0, 8'd0,
			8'h80, 1'b1));
	endtask

	// A wave with zero duration never ends and blocks later waves
	task automatic test_stuck_wave();
		wait_drained();
		program_registers(16'hBEEF, 8'd0, 5'd3);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (wave_m != PHASE_IDLE)
			send_ticks(1);
		send_item(make_item(REQ_BEACON, 16'h0101, 8'd0, CODE_BLINK, 8'd0, 8'd1, 8'd0,
			8'h33, 1'b1));
		send_ticks(6);
		send_item(make_item(REQ_BEACON, 16'h0202, 8'd1, CODE_YELLOW_OFF, 8'd1, 8'd0, 8'd0,
			8'h33, 1'b1));
		send_item(make_item(REQ_BEACON, 16'h0303, 8'd1, CODE_BLINK, 8'd2, 8'd0, 8'd0,
			8'h33, 1'b1));
		send_ticks(4);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LOCAL_ADDRESS;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_TICK;
		sender = '0;
		beacon_hops = '0;
		command = '0;
		led_duration = '0;
		led_delay = '0;
		wave_reverse = '0;
		pot_request = '0;
		send_accepted = 1'b0;
		// model state after reset
		addr_reg = '0;
		refresh_reg = REFRESH_RESET;
		limit_reg = LIMIT_RESET;
		route_left = '0;
		parent_m = '0;
		level_m = '0;
		wave_m = PHASE_IDLE;
		delay_left = '0;
		lit_left = '0;
		heartbeat_m = '0;
		send_busy = 1'b0;
		yellow_m = 1'b0;
		green_m = 1'b0;
		pot_m = POT_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_traffic(280, 0, 0, 16'h0000, 8'd1, 5'd31);
		test_random_traffic(280, 84, 0, 16'hFFFF, 8'd0, 5'd2);
		test_random_traffic(280, 0, 84, 16'h5A3C, 8'd3, 5'd0);
		test_random_traffic(280, 21, 21, 16'hC0DE, 8'd2, 5'd1);
		test_backpressure();
		test_stuck_wave();
		wait_drained();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
